// ===== design/pwsm_pkg.sv =====
// Shared widths, register indexes and the divider word type for the source mapper.
package pwsm_pkg;

  localparam int unsigned CoordW = 12;
  localparam int unsigned CoefW  = 32;
  localparam int unsigned ProdW  = CoefW + CoordW + 1;
  localparam int unsigned SumW   = ProdW + 2;
  localparam int unsigned DenW   = 45;
  localparam int unsigned RemW   = 59;
  localparam int unsigned FracSh = 14;
  localparam int unsigned CfgIdxW = 4;

  localparam int unsigned DefSrcWidth  = 1024;
  localparam int unsigned DefSrcHeight = 1024;

  // Register indexes on the configuration port.
  localparam logic [CfgIdxW-1:0] RegCoefXx = 4'd0;
  localparam logic [CfgIdxW-1:0] RegCoefXy = 4'd1;
  localparam logic [CfgIdxW-1:0] RegCoefXt = 4'd2;
  localparam logic [CfgIdxW-1:0] RegCoefYx = 4'd3;
  localparam logic [CfgIdxW-1:0] RegCoefYy = 4'd4;
  localparam logic [CfgIdxW-1:0] RegCoefYt = 4'd5;
  localparam logic [CfgIdxW-1:0] RegPerspX = 4'd6;
  localparam logic [CfgIdxW-1:0] RegPerspY = 4'd7;

  // Word handed from one divider cell to the next.
  typedef struct packed {
    logic [RemW-1:0]   rem_u;
    logic [RemW-1:0]   rem_v;
    logic [DenW-1:0]   den;
    logic [CoordW-1:0] q_u;
    logic [CoordW-1:0] q_v;
    logic              ok;
  } div_word_t;

endpackage

// ===== design/pwsm_front.sv =====
// Front end: products, numerator and denominator sums, and the range checks.
module pwsm_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [pwsm_pkg::CoefW-1:0]        coef_i [8],
  input  logic                              valid_i,
  output logic                              ready_o,
  input  logic [pwsm_pkg::CoordW-1:0]       x_i,
  input  logic [pwsm_pkg::CoordW-1:0]       y_i,
  output logic                              valid_o,
  input  logic                              ready_i,
  output pwsm_pkg::div_word_t               word_o
);

  logic signed [pwsm_pkg::ProdW-1:0] prod_q [6];
  logic signed [pwsm_pkg::ProdW-1:0] prod_d [6];
  logic signed [pwsm_pkg::SumW-1:0]  nu_q, nv_q, w_q;
  logic                              v1_q, v2_q, v3_q;
  logic                              rdy1, rdy2, rdy3;
  logic signed [pwsm_pkg::CoordW:0]  xs, ys;
  logic [pwsm_pkg::RemW-1:0]         nu_sh, nv_sh, den_lim;
  logic [pwsm_pkg::DenW-1:0]         den;
  logic                              pos_ok;
  pwsm_pkg::div_word_t               word_q, word_d;

  assign rdy3    = !v3_q || ready_i;
  assign rdy2    = !v2_q || rdy3;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;
  assign valid_o = v3_q;
  assign word_o  = word_q;

  // Six products of a coefficient with a coordinate.
  assign xs = $signed({1'b0, x_i});
  assign ys = $signed({1'b0, y_i});
  always_comb begin
    prod_d[0] = $signed(coef_i[0]) * xs;
    prod_d[1] = $signed(coef_i[1]) * ys;
    prod_d[2] = $signed(coef_i[3]) * xs;
    prod_d[3] = $signed(coef_i[4]) * ys;
    prod_d[4] = $signed(coef_i[6]) * xs;
    prod_d[5] = $signed(coef_i[7]) * ys;
  end

  // Numerators are scaled by 2^14 so both share the denominator's Q15.30 scale.
  assign den     = w_q[pwsm_pkg::DenW-1:0];
  assign nu_sh   = {nu_q[pwsm_pkg::RemW-pwsm_pkg::FracSh-1:0], {pwsm_pkg::FracSh{1'b0}}};
  assign nv_sh   = {nv_q[pwsm_pkg::RemW-pwsm_pkg::FracSh-1:0], {pwsm_pkg::FracSh{1'b0}}};
  assign den_lim = {2'b00, den, {pwsm_pkg::CoordW{1'b0}}};
  assign pos_ok  = (w_q > 0) && !nu_q[pwsm_pkg::SumW-1] && !nv_q[pwsm_pkg::SumW-1];

  // A quotient of 2^12 or more is out of any image, so it fails here.
  always_comb begin
    word_d.rem_u = nu_sh;
    word_d.rem_v = nv_sh;
    word_d.den   = den;
    word_d.q_u   = '0;
    word_d.q_v   = '0;
    word_d.ok    = pos_ok && (nu_sh < den_lim) && (nv_sh < den_lim);
  end

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk_i) begin
    if (rdy1 && valid_i) prod_q <= prod_d;
    if (rdy2 && v1_q) begin
      nu_q <= pwsm_pkg::SumW'(prod_q[0]) + pwsm_pkg::SumW'(prod_q[1])
              + pwsm_pkg::SumW'($signed(coef_i[2]));
      nv_q <= pwsm_pkg::SumW'(prod_q[2]) + pwsm_pkg::SumW'(prod_q[3])
              + pwsm_pkg::SumW'($signed(coef_i[5]));
      w_q  <= pwsm_pkg::SumW'(prod_q[4]) + pwsm_pkg::SumW'(prod_q[5])
              + (pwsm_pkg::SumW'(1) <<< 30);
    end
    if (rdy3 && v2_q) word_q <= word_d;
  end

endmodule

// ===== design/pwsm_div_cell.sv =====
// One restoring-division cell: settles one quotient bit for both coordinates.
module pwsm_div_cell #(
  parameter int unsigned BitPos = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  pwsm_pkg::div_word_t word_i,
  output logic                valid_o,
  input  logic                ready_i,
  output pwsm_pkg::div_word_t word_o
);

  logic                  valid_q;
  pwsm_pkg::div_word_t   word_q, word_d;
  logic [pwsm_pkg::RemW-1:0] step;
  logic                  ge_u, ge_v;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign word_o  = word_q;

  // Compare each remainder with the shifted divisor and subtract when it fits.
  assign step = pwsm_pkg::RemW'(word_i.den) << BitPos;
  assign ge_u = word_i.rem_u >= step;
  assign ge_v = word_i.rem_v >= step;
  always_comb begin
    word_d = word_i;
    if (ge_u) word_d.rem_u = word_i.rem_u - step;
    if (ge_v) word_d.rem_v = word_i.rem_v - step;
    word_d.q_u[BitPos] = ge_u;
    word_d.q_v[BitPos] = ge_v;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) word_q <= word_d;
  end

endmodule

// ===== design/perspective_warp_source_mapper_core.sv =====
// Maps a destination pixel back through a homography to a floored source pixel.
// One destination pixel is accepted per clock while s_axis_tready is high; it passes
// three front stages (products, sums, range checks) and a chain of twelve divider cells,
// each settling one quotient bit of u and v. Every stage holds its word while the output
// is stalled, so the block keeps accepting until the chain is full. The user must write
// coefficients on the cfg port only while the block is idle; it does not enforce this.
module perspective_warp_source_mapper_core #(
  parameter int unsigned SRC_WIDTH  = pwsm_pkg::DefSrcWidth,
  parameter int unsigned SRC_HEIGHT = pwsm_pkg::DefSrcHeight
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [pwsm_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // dst_x [11:0], dst_y [23:12]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // src_x [11:0], src_y [23:12], src_valid [24]
);

  localparam int unsigned NCells = pwsm_pkg::CoordW;

  logic [pwsm_pkg::CoefW-1:0] coef_q [8];
  logic                       vld [NCells+1];
  logic                       rdy [NCells+1];
  pwsm_pkg::div_word_t        wrd [NCells+1];
  pwsm_pkg::div_word_t        last;
  logic                       hit;

  // Coefficient registers; writes beyond the list are dropped.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q[0] <= 32'd65536;
      coef_q[1] <= '0;
      coef_q[2] <= '0;
      coef_q[3] <= '0;
      coef_q[4] <= 32'd65536;
      coef_q[5] <= '0;
      coef_q[6] <= '0;
      coef_q[7] <= '0;
    end else if (cfg_valid_i && !cfg_index_i[3]) begin
      coef_q[cfg_index_i[2:0]] <= cfg_data_i;
    end
  end

  pwsm_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .coef_i  (coef_q),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .x_i     (s_axis_tdata[11:0]),
    .y_i     (s_axis_tdata[23:12]),
    .valid_o (vld[0]),
    .ready_i (rdy[0]),
    .word_o  (wrd[0])
  );

  // Divider chain, most significant quotient bit first.
  for (genvar k = 0; k < NCells; k++) begin : g_cell
    pwsm_div_cell #(.BitPos(NCells - 1 - k)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld[k]),
      .ready_o (rdy[k]),
      .word_i  (wrd[k]),
      .valid_o (vld[k+1]),
      .ready_i (rdy[k+1]),
      .word_o  (wrd[k+1])
    );
  end

  assign rdy[NCells]   = m_axis_tready;
  assign m_axis_tvalid = vld[NCells];

  // Bound check against the source image and zeroing of a miss.
  assign last = wrd[NCells];
  assign hit  = last.ok
             && ({1'b0, last.q_u} < (pwsm_pkg::CoordW+1)'(SRC_WIDTH))
             && ({1'b0, last.q_v} < (pwsm_pkg::CoordW+1)'(SRC_HEIGHT));
  assign m_axis_tdata = {7'd0, hit,
                         hit ? last.q_v : 12'd0,
                         hit ? last.q_u : 12'd0};

endmodule
